### design/dclpt_pkg.sv
// Shared types and constants for the dual-channel log/packet transmitter.
// No dependencies; imported by the top level and its checker.
package dclpt_pkg;

    // Default queue depths
    localparam int WORD_QUEUE_DEPTH_DEF = 64;
    localparam int BYTE_QUEUE_DEPTH_DEF = 1024;

    // Packet walk positions and framing constants
    localparam int PIDX_W         = 18;
    localparam int HEADER_LAST    = 7;
    localparam int LEN_LOW_IDX    = 8;
    localparam int LEN_HIGH_IDX   = 9;
    localparam int FRAME_BYTES    = 8;
    localparam int PKT_START_MIN  = 8;

    // APB register map (word index within paddr[3:2])
    localparam int PADDR_W = 4;
    typedef enum logic [1:0] {
        REG_START_BYTE      = 2'd0,
        REG_LOCAL_ADDRESS   = 2'd1,
        REG_DISPLAY_ADDRESS = 2'd2,
        REG_UNUSED          = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_PUSH_WORD = 2'd0,
        OP_PUSH_BYTE = 2'd1,
        OP_START     = 2'd2,
        OP_CONTINUE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_LOG    = 2'd1,
        MODE_PACKET = 2'd2
    } t_mode;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_data;
        logic [1:0]  channel_state;
        logic        empty_irq_enable;
        logic        word_dropped;
        logic        byte_dropped;
    } t_result;

endpackage

### design/dual_channel_log_packet_transmitter_top.sv
// Top level of the dual-channel log/packet transmitter: queues, framer, packet walker.
// Depends on dclpt_pkg.
//
// Each result beat is registered at the output, or parked in the skid entry on a stall.
// Throughput: one item per cycle unless the skid entry is full; each queue keeps its
//   head prefetched from its single-port-read memory; a pop never waits on the read.
// Reset: synchronous, active low; queues empty, channel idle, registers at defaults.
// No clearing pass: queue memories hold no meaning until written.
module dual_channel_log_packet_transmitter_top #(
    parameter int WORD_QUEUE_DEPTH = dclpt_pkg::WORD_QUEUE_DEPTH_DEF,
    parameter int BYTE_QUEUE_DEPTH = dclpt_pkg::BYTE_QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_operation,
    input  logic [31:0]                   i_log_word,
    input  logic [7:0]                    i_packet_byte,
    input  logic                          i_uart_empty,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_tx_valid,
    output logic [7:0]                    o_tx_data,
    output logic [1:0]                    o_channel_state,
    output logic                          o_empty_irq_enable,
    output logic                          o_word_dropped,
    output logic                          o_byte_dropped,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dclpt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import dclpt_pkg::*;

    localparam int WQ_PTR_W = (WORD_QUEUE_DEPTH > 1) ? $clog2(WORD_QUEUE_DEPTH) : 1;
    localparam int WQ_CNT_W = $clog2(WORD_QUEUE_DEPTH + 1);
    localparam int BQ_PTR_W = (BYTE_QUEUE_DEPTH > 1) ? $clog2(BYTE_QUEUE_DEPTH) : 1;
    localparam int BQ_CNT_W = $clog2(BYTE_QUEUE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] r_start_byte, r_local_address, r_display_address;
    logic       cfg_wr;
    t_reg_idx   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte      <= 8'd235;
            r_local_address   <= 8'd96;
            r_display_address <= 8'd96;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_START_BYTE:      r_start_byte      <= pwdata[7:0];
                REG_LOCAL_ADDRESS:   r_local_address   <= pwdata[7:0];
                REG_DISPLAY_ADDRESS: r_display_address <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_START_BYTE:      prdata = {24'd0, r_start_byte};
            REG_LOCAL_ADDRESS:   prdata = {24'd0, r_local_address};
            REG_DISPLAY_ADDRESS: prdata = {24'd0, r_display_address};
            default:             prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Result buffer: output register plus one skid entry
    // ------------------------------------------------------------------
    t_result r_out, r_skid, result;
    logic    r_out_valid, r_skid_valid;
    logic    in_acc;

    assign o_in_ready = !r_skid_valid;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= r_skid_valid || in_acc;
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_acc) begin
                // output stalled: park the new beat
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : result;
        end
        if (r_out_valid && !i_out_ready && in_acc) begin
            r_skid <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_tx_valid         = r_out.tx_valid;
    assign o_tx_data          = r_out.tx_data;
    assign o_channel_state    = r_out.channel_state;
    assign o_empty_irq_enable = r_out.empty_irq_enable;
    assign o_word_dropped     = r_out.word_dropped;
    assign o_byte_dropped     = r_out.byte_dropped;

    // ------------------------------------------------------------------
    // Word queue: memory with prefetched head and write forwarding
    // ------------------------------------------------------------------
    logic [31:0]         r_wq_mem [WORD_QUEUE_DEPTH];
    logic [WQ_PTR_W-1:0] r_wq_rd, r_wq_wr, n_wq_rd;
    logic [WQ_CNT_W-1:0] r_wq_cnt;
    logic [31:0]         r_wq_rdata, r_wq_fwd_data, wq_head;
    logic                r_wq_fwd;
    logic                wq_push, wq_pop;

    assign n_wq_rd = !wq_pop ? r_wq_rd :
                     (r_wq_rd == WQ_PTR_W'(WORD_QUEUE_DEPTH - 1)) ? '0 : r_wq_rd + 1'b1;
    assign wq_head = r_wq_fwd ? r_wq_fwd_data : r_wq_rdata;

    always_ff @(posedge i_clk) begin
        if (wq_push) begin
            r_wq_mem[r_wq_wr] <= i_log_word;
        end
        r_wq_rdata    <= r_wq_mem[n_wq_rd];
        r_wq_fwd_data <= i_log_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wq_rd  <= '0;
            r_wq_wr  <= '0;
            r_wq_cnt <= '0;
            r_wq_fwd <= 1'b0;
        end else begin
            // catch a write landing on the entry being read this cycle
            r_wq_fwd <= wq_push && (r_wq_wr == n_wq_rd);
            r_wq_rd  <= n_wq_rd;
            if (wq_push) begin
                r_wq_wr  <= (r_wq_wr == WQ_PTR_W'(WORD_QUEUE_DEPTH - 1)) ? '0 : r_wq_wr + 1'b1;
                r_wq_cnt <= r_wq_cnt + 1'b1;
            end else if (wq_pop) begin
                r_wq_cnt <= r_wq_cnt - 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte queue: same organization
    // ------------------------------------------------------------------
    logic [7:0]          r_bq_mem [BYTE_QUEUE_DEPTH];
    logic [BQ_PTR_W-1:0] r_bq_rd, r_bq_wr, n_bq_rd;
    logic [BQ_CNT_W-1:0] r_bq_cnt;
    logic [7:0]          r_bq_rdata, r_bq_fwd_data, bq_head;
    logic                r_bq_fwd;
    logic                bq_push, bq_pop;

    assign n_bq_rd = !bq_pop ? r_bq_rd :
                     (r_bq_rd == BQ_PTR_W'(BYTE_QUEUE_DEPTH - 1)) ? '0 : r_bq_rd + 1'b1;
    assign bq_head = r_bq_fwd ? r_bq_fwd_data : r_bq_rdata;

    always_ff @(posedge i_clk) begin
        if (bq_push) begin
            r_bq_mem[r_bq_wr] <= i_packet_byte;
        end
        r_bq_rdata    <= r_bq_mem[n_bq_rd];
        r_bq_fwd_data <= i_packet_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bq_rd  <= '0;
            r_bq_wr  <= '0;
            r_bq_cnt <= '0;
            r_bq_fwd <= 1'b0;
        end else begin
            r_bq_fwd <= bq_push && (r_bq_wr == n_bq_rd);
            r_bq_rd  <= n_bq_rd;
            if (bq_push) begin
                r_bq_wr  <= (r_bq_wr == BQ_PTR_W'(BYTE_QUEUE_DEPTH - 1)) ? '0 : r_bq_wr + 1'b1;
                r_bq_cnt <= r_bq_cnt + 1'b1;
            end else if (bq_pop) begin
                r_bq_cnt <= r_bq_cnt - 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Channel state
    // ------------------------------------------------------------------
    t_mode              r_mode, n_mode;
    logic [63:0]        r_frame, n_frame;
    logic [3:0]         r_left, n_left;
    logic [PIDX_W-1:0]  r_pidx, n_pidx, pidx_inc;
    logic [7:0]         r_pkgs, n_pkgs, pkgs_dec;
    logic [PIDX_W-1:0]  r_end, n_end;
    logic [7:0]         r_len_low, n_len_low;
    logic [3:0]         frame_sel;
    logic [7:0]         crc;
    t_op                op;

    // control events of the current item
    logic ev_start_pkt, ev_start_log, ev_log_end, ev_pkt_done;
    logic tx_valid;
    logic [7:0] tx_data;

    assign op        = t_op'(i_operation);
    assign pidx_inc  = r_pidx + 1'b1;
    assign pkgs_dec  = r_pkgs - 1'b1;
    assign frame_sel = 4'(FRAME_BYTES) - r_left;
    assign crc       = r_start_byte ^ r_local_address ^ r_display_address ^
                       wq_head[7:0] ^ wq_head[15:8] ^ wq_head[23:16] ^ wq_head[31:24];

    // Datapath and control events for one item
    always_comb begin
        wq_push      = 1'b0;
        bq_push      = 1'b0;
        wq_pop       = 1'b0;
        bq_pop       = 1'b0;
        ev_start_pkt = 1'b0;
        ev_start_log = 1'b0;
        ev_log_end   = 1'b0;
        ev_pkt_done  = 1'b0;
        tx_valid     = 1'b0;
        tx_data      = 8'd0;
        n_frame      = r_frame;
        n_left       = r_left;
        n_pidx       = r_pidx;
        n_pkgs       = r_pkgs;
        n_end        = r_end;
        n_len_low    = r_len_low;
        if (in_acc) begin
            case (op)
                OP_PUSH_WORD: begin
                    wq_push = (r_wq_cnt < WQ_CNT_W'(WORD_QUEUE_DEPTH));
                end
                OP_PUSH_BYTE: begin
                    bq_push = (r_bq_cnt < BQ_CNT_W'(BYTE_QUEUE_DEPTH));
                end
                OP_START: begin
                    if (r_mode == MODE_IDLE && i_uart_empty) begin
                        if (r_bq_cnt >= BQ_CNT_W'(PKT_START_MIN)) begin
                            ev_start_pkt = 1'b1;
                            n_pidx       = '1;
                        end else if (r_wq_cnt != '0) begin
                            ev_start_log = 1'b1;
                            wq_pop       = 1'b1;
                            n_frame      = {wq_head, crc, r_display_address,
                                            r_local_address, r_start_byte};
                            n_left       = 4'(FRAME_BYTES);
                        end
                    end
                end
                default: begin
                    if (i_uart_empty && r_mode == MODE_LOG) begin
                        if (r_left != 4'd0 && r_left <= 4'(FRAME_BYTES)) begin
                            tx_valid = 1'b1;
                            tx_data  = r_frame[{frame_sel[2:0], 3'b000} +: 8];
                            n_left   = r_left - 1'b1;
                        end else begin
                            // frame sent: drop back to idle without a byte
                            n_left     = 4'd0;
                            ev_log_end = 1'b1;
                        end
                    end else if (i_uart_empty && r_mode == MODE_PACKET &&
                                 r_bq_cnt != '0) begin
                        bq_pop   = 1'b1;
                        tx_valid = 1'b1;
                        tx_data  = bq_head;
                        n_pidx   = pidx_inc;
                        if (pidx_inc < PIDX_W'(HEADER_LAST)) begin
                            n_pidx = pidx_inc;
                        end else if (pidx_inc == PIDX_W'(HEADER_LAST)) begin
                            n_pkgs = bq_head;
                            if (bq_head == 8'd0) begin
                                ev_pkt_done = 1'b1;
                                n_pidx      = '1;
                            end
                        end else if (pidx_inc == PIDX_W'(LEN_LOW_IDX)) begin
                            n_len_low = bq_head;
                        end else if (pidx_inc == PIDX_W'(LEN_HIGH_IDX)) begin
                            n_end = PIDX_W'(LEN_HIGH_IDX) + PIDX_W'({bq_head, r_len_low})
                                  + 1'b1;
                        end else if (pidx_inc >= r_end) begin
                            n_pkgs = pkgs_dec;
                            if (pkgs_dec == 8'd0) begin
                                ev_pkt_done = 1'b1;
                                n_pidx      = '1;
                            end else begin
                                // walk the next package from its length bytes
                                n_pidx = PIDX_W'(HEADER_LAST);
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Next channel mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_IDLE: begin
                if (ev_start_pkt) begin
                    n_mode = MODE_PACKET;
                end else if (ev_start_log) begin
                    n_mode = MODE_LOG;
                end
            end
            MODE_LOG: begin
                if (ev_log_end) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_PACKET: begin
                if (ev_pkt_done) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: n_mode = MODE_IDLE;
        endcase
    end

    // Result of the item
    always_comb begin
        result.tx_valid         = tx_valid;
        result.tx_data          = tx_data;
        result.channel_state    = n_mode;
        result.empty_irq_enable = (n_mode != MODE_IDLE);
        result.word_dropped     = in_acc && op == OP_PUSH_WORD && !wq_push;
        result.byte_dropped     = in_acc && op == OP_PUSH_BYTE && !bq_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_left <= 4'd0;
            r_pidx <= '1;
        end else begin
            r_mode <= n_mode;
            r_left <= n_left;
            r_pidx <= n_pidx;
        end
    end

    // frame and package bookkeeping are always written before they are read
    always_ff @(posedge i_clk) begin
        r_frame   <= n_frame;
        r_pkgs    <= n_pkgs;
        r_end     <= n_end;
        r_len_low <= n_len_low;
    end

endmodule

### design/dclpt_checker.sv
// Port-level checks for the dual-channel log/packet transmitter, bound to the top level.
// Depends on dclpt_pkg and dual_channel_log_packet_transmitter_top.
module dclpt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_data,
    input logic [1:0] o_channel_state,
    input logic       o_empty_irq_enable,
    input logic       o_word_dropped,
    input logic       o_byte_dropped
);
    import dclpt_pkg::*;

    // interrupt enable tracks whether a channel is active
    a_irq_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_empty_irq_enable == (o_channel_state != 2'(MODE_IDLE))))
        else $error("irq enable disagrees with channel state");

    // no byte, no data
    a_idle_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tx_valid) |-> (o_tx_data == 8'd0))
        else $error("tx_data nonzero without tx_valid");

    // a push never emits a byte and raises at most one drop flag
    a_drop_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_word_dropped || o_byte_dropped)) |->
            (!o_tx_valid && !(o_word_dropped && o_byte_dropped)))
        else $error("drop flag with transmitted byte or both drops");

    // input stalls only while a result beat is waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_tx_data) && $stable(o_channel_state)))
        else $error("stalled result changed");

endmodule

bind dual_channel_log_packet_transmitter_top dclpt_checker u_dclpt_checker (.*);
